FILE: rtl/cnrh_pkg.sv
// ----------------------------------------------------------------------------
// cnrh_pkg: shared types and constants for the clear-normalized RGB to HSL
// Widths of the sensor channels, percent and hue constants, and the lane
// record that travels through the restoring divider cells.
// ----------------------------------------------------------------------------
package cnrh_pkg;

  // channel and result widths
  localparam int CH_W   = 16;  // raw sensor count
  localparam int PCT_W  = 7;   // percent 0..100
  localparam int HUE_W  = 9;   // degrees 0..359
  localparam int SUM_W  = 8;   // max+min, 0..200
  localparam int PROD_W = 23;  // count*100
  localparam int QW     = 7;   // quotient bits per divider row (one cell each)

  // percent and hue constants
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] LIGHT_MID = 7'd50;
  localparam logic [SUM_W-1:0] SUM_FULL  = 8'd200;
  localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
  localparam logic [HUE_W-1:0] HUE_GRN   = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLU   = 9'd240;
  localparam logic [12:0]      HUE_STEP  = 13'd60;

  // one division in flight: partial remainder, divisor, and a shift word
  // that feeds dividend bits out the top and takes quotient bits in below
  typedef struct packed {
    logic [CH_W-1:0] rem;
    logic [CH_W-1:0] den;
    logic [QW-1:0]   nq;
  } lane_t;

endpackage

FILE: rtl/clear_normalized_rgb_to_hsl.sv
// ----------------------------------------------------------------------------
// clear_normalized_rgb_to_hsl: color sensor reading to hue, saturation, lightness
// Takes one beat per cycle and returns one result beat per input beat when
// the output is not stalled; the pipeline is two rows of seven divider
// cells (one quotient bit per cell) plus four register stages.
// Each color is scaled to percent of clear (saturating at 100), then hue in
// degrees and saturation and lightness in percent are derived with
// truncating division. A zero clear count returns all-zero results with
// zero_clear set. A result waiting in the output register freezes the whole
// pipeline and holds in_tready low; a new beat enters in the same cycle the
// waiting result is taken.
// ----------------------------------------------------------------------------
module clear_normalized_rgb_to_hsl
  import cnrh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // red[15:0], green[31:16], blue[47:32], clear[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // hue[8:0], saturation[15:9], lightness[22:16], pad
  output logic [0:0]  out_tuser   // zero_clear[0]
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GRN,
    SEC_BLU
  } sector_t;

  // pipeline advances whenever the output register is free or being taken
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ------------------------------------------------------------------
  // input stage: scale by 100 and set up the percent divisions
  // ------------------------------------------------------------------
  function automatic logic [PROD_W-1:0] scale100(input logic [CH_W-1:0] c);
    return {7'b0, c} * 23'(PCT_FULL);
  endfunction

  logic [CH_W-1:0]   in_red, in_grn, in_blu, in_clr;
  logic [PROD_W-1:0] prod [3];
  logic [CH_W-1:0]   chan [3];
  lane_t             lane0_nxt [3];
  logic [2:0]        sat0_nxt;

  assign in_red = in_tdata[15:0];
  assign in_grn = in_tdata[31:16];
  assign in_blu = in_tdata[47:32];
  assign in_clr = in_tdata[63:48];
  assign chan[0] = in_red;
  assign chan[1] = in_grn;
  assign chan[2] = in_blu;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]          = scale100(chan[i]);
      // a quotient of 128 or more clamps to 100 anyway
      sat0_nxt[i]      = (prod[i] >= {in_clr, 7'b0});
      lane0_nxt[i].den = in_clr;
      lane0_nxt[i].rem = sat0_nxt[i] ? '0 : prod[i][PROD_W-1:QW];
      lane0_nxt[i].nq  = prod[i][QW-1:0];
    end
  end

  logic       v0_r;
  lane_t      lane0_r [3];
  logic [2:0] sat0_r;
  logic       zero0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lane0_r <= lane0_nxt;
      sat0_r  <= sat0_nxt;
      zero0_r <= (in_clr == '0);
    end
  end

  // ------------------------------------------------------------------
  // percent division rows, flags ride alongside
  // ------------------------------------------------------------------
  lane_t lane1 [3];

  for (genvar i = 0; i < 3; i++) begin : g_pct
    cnrh_div_row u_row (
      .clk    (clk),
      .en     (en),
      .lane_i (lane0_r[i]),
      .lane_o (lane1[i])
    );
  end

  logic [QW-1:0] v1_r;
  logic [2:0]    sat1_r  [QW];
  logic [QW-1:0] zero1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sat1_r[0] <= sat0_r;
      for (int k = 1; k < QW; k++) begin
        sat1_r[k] <= sat1_r[k-1];
      end
      zero1_r <= {zero1_r[QW-2:0], zero0_r};
    end
  end

  // ------------------------------------------------------------------
  // percent clamp stage
  // ------------------------------------------------------------------
  logic [PCT_W-1:0] pct_nxt [3];
  logic [PCT_W-1:0] pct_r   [3];
  logic             vp_r;
  logic             zerop_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sat1_r[QW-1][i] || (lane1[i].nq > PCT_FULL)) begin
        pct_nxt[i] = PCT_FULL;
      end else begin
        pct_nxt[i] = lane1[i].nq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pct_r   <= pct_nxt;
      zerop_r <= zero1_r[QW-1];
    end
  end

  // ------------------------------------------------------------------
  // setup stage: max, min, sector and the hue and saturation divisions
  // ------------------------------------------------------------------
  logic [PCT_W-1:0] r, g, b, mx, mn, dif, ha, hb, had;
  logic [SUM_W-1:0] sum, sden;
  logic [PCT_W-1:0] light;
  logic [12:0]      hnum;
  logic [13:0]      snum;
  logic             hneg;
  sector_t          sec_nxt;
  lane_t            hlane_nxt, slane_nxt;

  always_comb begin
    r = pct_r[0];
    g = pct_r[1];
    b = pct_r[2];
    // ties: red over green, green over blue
    if (r >= g && r >= b) begin
      sec_nxt = SEC_RED;
      mx      = r;
      ha      = g;
      hb      = b;
    end else if (g >= b) begin
      sec_nxt = SEC_GRN;
      mx      = g;
      ha      = b;
      hb      = r;
    end else begin
      sec_nxt = SEC_BLU;
      mx      = b;
      ha      = r;
      hb      = g;
    end
    mn    = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    dif   = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    light = sum[SUM_W-1:1];
    hneg  = (ha < hb);
    had   = hneg ? (hb - ha) : (ha - hb);
    hnum  = {6'b0, had} * HUE_STEP;
    sden  = (light <= LIGHT_MID) ? sum : (SUM_FULL - sum);
    snum  = {7'b0, dif} * 14'(PCT_FULL);
    // both quotients stay below 128, so the top bits fit under the divisor
    hlane_nxt.den = {9'b0, dif};
    hlane_nxt.rem = {10'b0, hnum[12:QW]};
    hlane_nxt.nq  = hnum[QW-1:0];
    slane_nxt.den = {8'b0, sden};
    slane_nxt.rem = {9'b0, snum[13:QW]};
    slane_nxt.nq  = snum[QW-1:0];
  end

  logic             vh_r;
  lane_t            hlane_r, slane_r;
  sector_t          sech_r;
  logic             negh_r, greyh_r, zeroh_r;
  logic [PCT_W-1:0] lighth_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hlane_r  <= hlane_nxt;
      slane_r  <= slane_nxt;
      sech_r   <= sec_nxt;
      negh_r   <= hneg;
      greyh_r  <= (dif == '0);
      zeroh_r  <= zerop_r;
      lighth_r <= light;
    end
  end

  // ------------------------------------------------------------------
  // hue and saturation division rows
  // ------------------------------------------------------------------
  lane_t hlane2, slane2;

  cnrh_div_row u_hue_row (
    .clk    (clk),
    .en     (en),
    .lane_i (hlane_r),
    .lane_o (hlane2)
  );

  cnrh_div_row u_sat_row (
    .clk    (clk),
    .en     (en),
    .lane_i (slane_r),
    .lane_o (slane2)
  );

  logic [QW-1:0]    v2_r;
  sector_t          sec2_r   [QW];
  logic [QW-1:0]    neg2_r, grey2_r, zero2_r;
  logic [PCT_W-1:0] light2_r [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      sec2_r[0]   <= sech_r;
      light2_r[0] <= lighth_r;
      for (int k = 1; k < QW; k++) begin
        sec2_r[k]   <= sec2_r[k-1];
        light2_r[k] <= light2_r[k-1];
      end
      neg2_r  <= {neg2_r[QW-2:0], negh_r};
      grey2_r <= {grey2_r[QW-2:0], greyh_r};
      zero2_r <= {zero2_r[QW-2:0], zeroh_r};
    end
  end

  // ------------------------------------------------------------------
  // hue assembly and output register
  // ------------------------------------------------------------------
  logic [HUE_W-1:0] hq, hue_nxt;
  logic [PCT_W-1:0] sat_nxt, light_nxt;
  logic             zero_f, grey_f, neg_f;

  always_comb begin
    hq     = {2'b0, hlane2.nq};
    zero_f = zero2_r[QW-1];
    grey_f = grey2_r[QW-1];
    neg_f  = neg2_r[QW-1];
    case (sec2_r[QW-1])
      SEC_RED: begin
        // a zero term below the axis wraps 360 back to 0
        hue_nxt = (neg_f && hq != '0) ? (HUE_FULL - hq) : hq;
      end
      SEC_GRN: begin
        hue_nxt = neg_f ? (HUE_GRN - hq) : (HUE_GRN + hq);
      end
      SEC_BLU: begin
        hue_nxt = neg_f ? (HUE_BLU - hq) : (HUE_BLU + hq);
      end
      default: begin
        hue_nxt = '0;
      end
    endcase
    sat_nxt   = slane2.nq;
    light_nxt = light2_r[QW-1];
    if (grey_f) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
    if (zero_f) begin
      hue_nxt   = '0;
      sat_nxt   = '0;
      light_nxt = '0;
    end
  end

  logic [23:0] out_tdata_r;
  logic [0:0]  out_tuser_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {1'b0, light_nxt, sat_nxt, hue_nxt};
      out_tuser_r <= zero_f;
    end
  end

  // valid bits along the whole pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= '0;
      vp_r        <= 1'b0;
      vh_r        <= 1'b0;
      v2_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_tvalid;
      v1_r        <= {v1_r[QW-2:0], v0_r};
      vp_r        <= v1_r[QW-1];
      vh_r        <= vp_r;
      v2_r        <= {v2_r[QW-2:0], vh_r};
      out_valid_r <= v2_r[QW-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: rtl/cnrh_div_cell.sv
// ----------------------------------------------------------------------------
// cnrh_div_cell: one restoring division step
// Shifts the next dividend bit into the remainder, subtracts the divisor when
// it fits and records the quotient bit. Registered, advances on en.
// ----------------------------------------------------------------------------
module cnrh_div_cell
  import cnrh_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_i,
  output lane_t lane_o
);

  logic [CH_W:0] trial;
  logic [CH_W:0] diff;
  logic          fits;
  lane_t         lane_nxt;
  lane_t         lane_r;

  // trial subtract of the shifted remainder
  always_comb begin
    trial        = {lane_i.rem, lane_i.nq[QW-1]};
    diff         = trial - {1'b0, lane_i.den};
    fits         = (trial >= {1'b0, lane_i.den});
    lane_nxt.den = lane_i.den;
    lane_nxt.rem = fits ? diff[CH_W-1:0] : trial[CH_W-1:0];
    lane_nxt.nq  = {lane_i.nq[QW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

FILE: rtl/cnrh_div_row.sv
// ----------------------------------------------------------------------------
// cnrh_div_row: row of divider cells, one quotient bit per cell
// A lane enters with its remainder below the divisor and leaves after the
// QW registered cells with the quotient in the nq field.
// ----------------------------------------------------------------------------
module cnrh_div_row
  import cnrh_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_i,
  output lane_t lane_o
);

  lane_t link [QW+1];

  assign link[0] = lane_i;

  // each cell hands its lane to the next one every cycle that en is high
  for (genvar k = 0; k < QW; k++) begin : g_cell
    cnrh_div_cell u_cell (
      .clk    (clk),
      .en     (en),
      .lane_i (link[k]),
      .lane_o (link[k+1])
    );
  end

  assign lane_o = link[QW];

endmodule

FILE: rtl/cnrh_checker.sv
// ----------------------------------------------------------------------------
// cnrh_checker: port-level checks for the RGB to HSL block
// Watches the stream ports for stall behavior, result ranges and the
// zero-clear result.
// ----------------------------------------------------------------------------
module cnrh_checker
  import cnrh_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a waiting sensor beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("sensor beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // input is only held off by a stalled result
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input not ready with free output");

  // results in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:0] < HUE_FULL && out_tdata[15:9] <= PCT_FULL
                   && out_tdata[22:16] <= PCT_FULL && out_tdata[23] == 1'b0)
    else $error("result field out of range");

  // zero clear forces every field to zero
  a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero clear result not all zero");

endmodule

bind clear_normalized_rgb_to_hsl cnrh_checker u_cnrh_checker (.*);
